// ===== rtl/core/rdq_pkg.sv =====
package rdq_pkg;

    localparam int CAP_W   = 5;
    localparam int DATA_W  = 32;
    localparam int BURST_W = 16;

    localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
    localparam logic [BURST_W-1:0] BURST_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_APPEND     = 3'd0,
        CMD_APPEND_OVW = 3'd1,
        CMD_PUSH_HEAD  = 3'd2,
        CMD_READ_HEAD  = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [DATA_W-1:0] write_data;
        logic              burst_end;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  read_data;
        logic               overwrote;
        logic [CAP_W-1:0]   item_count;
        logic [CAP_W-1:0]   free_count;
        logic               is_empty;
        logic               is_full;
        logic [BURST_W-1:0] burst_count;
    } t_rsp;

endpackage

// ===== rtl/core/rdq_ram.sv =====
module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rdq_ctrl.sv =====
module rdq_ctrl #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  rdq_pkg::t_req               i_req,
    input  logic                        i_cfg_we,
    input  logic [rdq_pkg::CAP_W-1:0]   i_cfg_wdata,
    output logic                        o_mem_we,
    output logic [$clog2(DEPTH)-1:0]    o_mem_waddr,
    output logic [WIDTH-1:0]            o_mem_wdata,
    output logic                        o_mem_re,
    output logic [$clog2(DEPTH)-1:0]    o_mem_raddr,
    output logic                        o_done,
    output logic                        o_rd_sel,
    output rdq_pkg::t_rsp               o_rsp
);

    localparam int IW     = $clog2(DEPTH);
    localparam int CW     = rdq_pkg::CAP_W;
    localparam int BW     = rdq_pkg::BURST_W;
    localparam int EW     = (IW > CW) ? IW : CW;
    localparam int CapMax = (DEPTH < 31) ? DEPTH : 31;

    logic [IW-1:0]               r_tail, n_tail;
    logic [IW-1:0]               r_head, n_head;
    logic                        r_full, n_full;
    logic [rdq_pkg::BURST_W-1:0] r_burst, n_burst;
    logic [CW-1:0]               r_cap;
    logic                        r_done;
    logic                        r_rd_sel;
    rdq_pkg::t_rsp               r_rsp;

    logic [CW-1:0]               cap_eff;
    logic                        empty;
    logic                        ok;
    logic                        dropped;
    logic                        rd_sel;
    logic [IW-1:0]               h_adj;
    logic [IW-1:0]               t_nxt;
    logic [rdq_pkg::BURST_W-1:0] burst_now;
    logic [EW-1:0]               held;
    logic [CW-1:0]               cnt;
    rdq_pkg::t_rsp               rsp;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx, input logic [CW-1:0] cap);
        logic [EW-1:0] inc;
        inc = EW'(idx) + EW'(1);
        return (inc == EW'(cap)) ? '0 : inc[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] idx, input logic [CW-1:0] cap);
        logic [EW-1:0] dec;
        dec = (idx == '0) ? (EW'(cap) - EW'(1)) : (EW'(idx) - EW'(1));
        return dec[IW-1:0];
    endfunction

    // zero acts as one, anything above the memory depth acts as the depth
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CW'(1);
        end else if (32'(r_cap) > CapMax) begin
            cap_eff = CW'(CapMax);
        end else begin
            cap_eff = r_cap;
        end
    end

    always_comb begin
        empty       = (r_tail == r_head) && !r_full;
        n_tail      = r_tail;
        n_head      = r_head;
        n_full      = r_full;
        ok          = 1'b0;
        dropped     = 1'b0;
        rd_sel      = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail;
        t_nxt       = f_next(r_tail, cap_eff);
        h_adj       = r_head;
        case (i_req.cmd)
            rdq_pkg::CMD_APPEND: begin
                if (!r_full) begin
                    o_mem_we = i_accept;
                    n_tail   = t_nxt;
                    n_full   = (t_nxt == r_head);
                    ok       = 1'b1;
                end
            end
            rdq_pkg::CMD_APPEND_OVW: begin
                if (r_full) begin
                    h_adj   = f_next(r_head, cap_eff);
                    dropped = 1'b1;
                end
                o_mem_we = i_accept;
                n_tail   = t_nxt;
                n_head   = h_adj;
                n_full   = (t_nxt == h_adj);
                ok       = 1'b1;
            end
            rdq_pkg::CMD_PUSH_HEAD: begin
                if (!r_full) begin
                    h_adj       = f_prev(r_head, cap_eff);
                    o_mem_we    = i_accept;
                    o_mem_waddr = h_adj;
                    n_head      = h_adj;
                    n_full      = (h_adj == r_tail);
                    ok          = 1'b1;
                end
            end
            rdq_pkg::CMD_READ_HEAD: begin
                if (!empty) begin
                    rd_sel = 1'b1;
                    n_head = f_next(r_head, cap_eff);
                    n_full = 1'b0;
                    ok     = 1'b1;
                end
            end
            rdq_pkg::CMD_CLEAR: begin
                n_tail = '0;
                n_head = '0;
                n_full = 1'b0;
                ok     = 1'b1;
            end
            default: begin
            end
        endcase

        burst_now = (ok && (r_burst != rdq_pkg::BURST_MAX)) ?
                    (r_burst + BW'(1)) : r_burst;
        n_burst   = i_req.burst_end ? '0 : burst_now;

        if (n_full) begin
            held = EW'(cap_eff);
        end else if (n_tail >= n_head) begin
            held = EW'(n_tail) - EW'(n_head);
        end else begin
            held = EW'(n_tail) + EW'(cap_eff) - EW'(n_head);
        end
        cnt = held[CW-1:0];

        rsp.ok          = ok;
        rsp.read_data   = '0;
        rsp.overwrote   = dropped;
        rsp.item_count  = cnt;
        rsp.free_count  = cap_eff - cnt;
        rsp.is_empty    = (cnt == '0);
        rsp.is_full     = n_full;
        rsp.burst_count = burst_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail   <= '0;
            r_head   <= '0;
            r_full   <= 1'b0;
            r_burst  <= '0;
            r_cap    <= rdq_pkg::CAP_RESET;
            r_done   <= 1'b0;
            r_rd_sel <= 1'b0;
        end else begin
            r_done <= i_accept;
            if (i_cfg_we) begin
                r_cap  <= i_cfg_wdata;
                r_tail <= '0;
                r_head <= '0;
                r_full <= 1'b0;
            end else if (i_accept) begin
                r_tail <= n_tail;
                r_head <= n_head;
                r_full <= n_full;
            end
            if (i_accept) begin
                r_burst  <= n_burst;
                r_rd_sel <= rd_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rsp <= rsp;
        end
    end

    assign o_mem_wdata = WIDTH'(i_req.write_data);
    assign o_mem_re    = i_accept && rd_sel;
    assign o_mem_raddr = r_head;
    assign o_done      = r_done;
    assign o_rd_sel    = r_rd_sel;
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/core/ring_deque_with_overwrite.sv =====
// ring deque with overwrite: append, overwrite append, head push, head read, clear
// the result strobe o_done comes in the cycle after the request is taken
// throughput: one request per cycle, busy stays low; set by the single ram port pair
// the receiver cannot stall, each result is shown for exactly one cycle
// reset (synchronous, active low): empty buffer, burst count zero, capacity 16;
// ram contents are not cleared, entries are only read after they were written
module ring_deque_with_overwrite #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rdq_pkg::t_req             i_req,
    input  logic                      i_cfg_we,
    input  logic [rdq_pkg::CAP_W-1:0] i_cfg_wdata,
    output logic                      o_done,
    output rdq_pkg::t_rsp             o_rsp
);

    localparam int IW     = $clog2(DEPTH);
    localparam int CapMax = (DEPTH < 31) ? DEPTH : 31;

    logic                 accept;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [WIDTH-1:0]     mem_wdata;
    logic                 mem_re;
    logic [IW-1:0]        mem_raddr;
    logic [WIDTH-1:0]     mem_rdata;
    logic [63:0]          rdata_wide;
    logic                 rd_sel;
    rdq_pkg::t_rsp        rsp_reg;

    // every request resolves in its accept cycle, so a new one can follow at once
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // index, flag, burst and capacity registers plus the registered result fields
    rdq_ctrl #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_done      (o_done),
        .o_rd_sel    (rd_sel),
        .o_rsp       (rsp_reg)
    );

    // element storage; a write is visible to any later read,
    // and one request never reads and writes at the same edge
    rdq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // read data lands in the result cycle straight from the ram output register
    assign rdata_wide = 64'(mem_rdata);

    always_comb begin
        o_rsp           = rsp_reg;
        o_rsp.read_data = rd_sel ? rdata_wide[rdq_pkg::DATA_W-1:0] : '0;
    end

    // a request always produces its result on the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept) |=> o_done)
        else $error("result strobe missing after accepted request");

    // counts always add up to a capacity in use
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((6'(o_rsp.item_count) + 6'(o_rsp.free_count)) != 6'd0 &&
                    (6'(o_rsp.item_count) + 6'(o_rsp.free_count)) <= 6'(CapMax)))
        else $error("item and free counts inconsistent");

    // empty and full are exclusive since capacity is at least one
    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.is_empty && o_rsp.is_full))
        else $error("buffer reported empty and full");

    // dropping the oldest only happens on a full buffer, which stays full
    a_overwrite_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.overwrote) |-> (o_rsp.ok && o_rsp.is_full))
        else $error("overwrite mark without full buffer");

endmodule

// ===== sim/tb.sv =====
module tb;

    localparam int DEPTH       = 16;
    localparam int CYCLE_CAP   = 600000;
    localparam int RAND_ITEMS  = 1200;
    localparam int BURST_ITEMS = 60;

    // command codes the block has no use for
    localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [2:0] CMD_BAD_LAST  = 3'd7;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    rdq_pkg::t_req             i_req       = '0;
    logic                      i_cfg_we    = 1'b0;
    logic [rdq_pkg::CAP_W-1:0] i_cfg_wdata = '0;
    logic                      o_done;
    rdq_pkg::t_rsp             o_rsp;

    ring_deque_with_overwrite #(
        .DEPTH(DEPTH),
        .WIDTH(rdq_pkg::DATA_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the deque
    logic [rdq_pkg::DATA_W-1:0] shadow_mem [DEPTH];
    int                         shadow_tail  = 0;
    int                         shadow_head  = 0;
    logic                       shadow_full  = 1'b0;
    int                         shadow_burst = 0;
    logic [rdq_pkg::CAP_W-1:0]  shadow_cap   = rdq_pkg::CAP_RESET;

    rdq_pkg::t_rsp due_rsp [$];
    int   cycles    = 0;
    int   n_taken   = 0;
    int   n_checked = 0;
    int   n_err     = 0;
    int   n_reads   = 0;
    int   n_drops   = 0;
    int   n_refused = 0;
    int   n_full    = 0;
    int   n_caps    = 0;
    logic no_idle   = 1'b0;

    function automatic rdq_pkg::t_rsp deque_apply(input rdq_pkg::t_req rq);
        rdq_pkg::t_rsp r;
        int   cap;
        int   cnt;
        int   fc;
        logic was_empty;
        cap = (shadow_cap == 0) ? 1 : (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
        r = '0;
        was_empty = (shadow_tail == shadow_head) && !shadow_full;
        case (rq.cmd)
            rdq_pkg::CMD_APPEND: begin
                if (!shadow_full) begin
                    shadow_mem[shadow_tail] = rq.write_data;
                    shadow_tail = (shadow_tail + 1) % cap;
                    shadow_full = (shadow_tail == shadow_head);
                    r.ok = 1'b1;
                end
            end
            rdq_pkg::CMD_APPEND_OVW: begin
                // full buffer: oldest element goes first
                if (shadow_full) begin
                    shadow_head = (shadow_head + 1) % cap;
                    r.overwrote = 1'b1;
                end
                shadow_mem[shadow_tail] = rq.write_data;
                shadow_tail = (shadow_tail + 1) % cap;
                shadow_full = (shadow_tail == shadow_head);
                r.ok = 1'b1;
            end
            rdq_pkg::CMD_PUSH_HEAD: begin
                if (!shadow_full) begin
                    shadow_head = (shadow_head + cap - 1) % cap;
                    shadow_mem[shadow_head] = rq.write_data;
                    shadow_full = (shadow_head == shadow_tail);
                    r.ok = 1'b1;
                end
            end
            rdq_pkg::CMD_READ_HEAD: begin
                if (!was_empty) begin
                    r.read_data = shadow_mem[shadow_head];
                    shadow_head = (shadow_head + 1) % cap;
                    shadow_full = 1'b0;
                    r.ok = 1'b1;
                end
            end
            rdq_pkg::CMD_CLEAR: begin
                shadow_tail = 0;
                shadow_head = 0;
                shadow_full = 1'b0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        if (r.ok && shadow_burst < int'(rdq_pkg::BURST_MAX))
            shadow_burst++;
        r.burst_count = shadow_burst[rdq_pkg::BURST_W-1:0];
        if (rq.burst_end)
            shadow_burst = 0;
        cnt = shadow_full ? cap : (shadow_tail + cap - shadow_head) % cap;
        fc  = cap - cnt;
        r.item_count = cnt[rdq_pkg::CAP_W-1:0];
        r.free_count = fc[rdq_pkg::CAP_W-1:0];
        r.is_empty   = (cnt == 0);
        r.is_full    = shadow_full;
        n_reads   += (r.ok && rq.cmd == rdq_pkg::CMD_READ_HEAD);
        n_drops   += r.overwrote;
        n_refused += !r.ok;
        n_full    += shadow_full;
        return r;
    endfunction

    task automatic compare_rsp(input rdq_pkg::t_rsp want, input rdq_pkg::t_rsp got);
        if (got.ok !== want.ok)
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
        if (got.read_data !== want.read_data)
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        if (got.overwrote !== want.overwrote)
            $error("overwrote: expected %0d, got %0d", want.overwrote, got.overwrote);
        if (got.item_count !== want.item_count)
            $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
        if (got.free_count !== want.free_count)
            $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
        if (got.is_empty !== want.is_empty)
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        if (got.is_full !== want.is_full)
            $error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
        if (got.burst_count !== want.burst_count)
            $error("burst_count: expected %0d, got %0d", want.burst_count, got.burst_count);
        if (got !== want)
            n_err++;
    endtask

    // result check first, then the request taken at this edge, then config
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("** ring_deque_with_overwrite: FAILED **");
            $finish;
        end else if (i_rst_n) begin
            if (o_done) begin
                if (due_rsp.size() == 0) begin
                    $error("result with no request outstanding");
                    n_err++;
                end else begin
                    compare_rsp(due_rsp.pop_front(), o_rsp);
                    n_checked++;
                end
            end
            if (start && !busy) begin
                due_rsp.push_back(deque_apply(i_req));
                n_taken++;
            end
            if (i_cfg_we) begin
                shadow_cap  = i_cfg_wdata;
                shadow_tail = 0;
                shadow_head = 0;
                shadow_full = 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rdq_pkg::DATA_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // fill-heavy or drain-heavy command mix so both full and empty get reached
    function automatic logic [2:0] pick_cmd(input logic filling);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 97)
            return 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
        if (r >= 94)
            return rdq_pkg::CMD_CLEAR;
        if (filling) begin
            if (r < 35) return rdq_pkg::CMD_APPEND;
            if (r < 60) return rdq_pkg::CMD_APPEND_OVW;
            if (r < 78) return rdq_pkg::CMD_PUSH_HEAD;
            return rdq_pkg::CMD_READ_HEAD;
        end
        if (r < 15) return rdq_pkg::CMD_APPEND;
        if (r < 22) return rdq_pkg::CMD_APPEND_OVW;
        if (r < 32) return rdq_pkg::CMD_PUSH_HEAD;
        return rdq_pkg::CMD_READ_HEAD;
    endfunction

    // one request; returns at the falling edge after it was taken, start still high
    task automatic send_req(input logic [2:0] c, input logic [rdq_pkg::DATA_W-1:0] d,
                            input logic last, input int gap);
        int taken_before;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        taken_before = n_taken;
        start <= 1'b1;
        i_req <= '{cmd: c, write_data: d, burst_end: last};
        do @(negedge i_clk); while (n_taken == taken_before);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        start <= 1'b0;
        while (due_rsp.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [rdq_pkg::CAP_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        n_caps++;
    endtask

    // reset capacity: empty read, data extremes, head push, unknown codes, clear
    task automatic test_reset_capacity();
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b0, 0);
        send_req(rdq_pkg::CMD_APPEND, '0, 1'b0, 0);
        send_req(rdq_pkg::CMD_APPEND, '1, 1'b0, 1);
        send_req(rdq_pkg::CMD_PUSH_HEAD, 32'h5A5A_A5A5, 1'b0, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b0, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '1, 1'b1, 2);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b0, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b0, 0);
        send_req(CMD_BAD_FIRST, '1, 1'b0, 0);
        send_req(CMD_BAD_LAST, '0, 1'b1, 0);
        send_req(rdq_pkg::CMD_APPEND, 32'h1234_5678, 1'b0, 0);
        send_req(rdq_pkg::CMD_CLEAR, '0, 1'b1, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b0, 0);
    endtask

    // zero capacity acts as one: refusals when full, overwrite drop, empty overwrite
    task automatic test_single_entry();
        set_capacity('0);
        send_req(rdq_pkg::CMD_APPEND, 32'hAAAA_0001, 1'b0, 0);
        send_req(rdq_pkg::CMD_APPEND, 32'hAAAA_0002, 1'b0, 0);
        send_req(rdq_pkg::CMD_PUSH_HEAD, 32'hAAAA_0003, 1'b0, 0);
        send_req(rdq_pkg::CMD_APPEND_OVW, 32'hAAAA_0004, 1'b0, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b0, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b1, 0);
        send_req(rdq_pkg::CMD_APPEND_OVW, 32'hFFFF_0000, 1'b0, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b1, 0);
    endtask

    // long burst with no end mark: the count keeps climbing through clears and drops
    task automatic test_long_burst();
        set_capacity(5'd3);
        for (int k = 0; k < BURST_ITEMS; k++)
            send_req((k % 7 == 0) ? rdq_pkg::CMD_CLEAR : rdq_pkg::CMD_APPEND_OVW,
                     $urandom, 1'b0, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b1, 0);
        send_req(rdq_pkg::CMD_READ_HEAD, '0, 1'b0, 0);
        drain();
    endtask

    // random traffic over a series of capacities, the extremes and out-of-range among them
    task automatic test_random_traffic();
        logic [rdq_pkg::CAP_W-1:0] caps [15];
        logic                      filling;
        int                        per_phase;
        caps = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd31, 5'd4, 5'd7, 5'd8, 5'd15, 5'd0, 5'd17,
                 5'd0, 5'd0, 5'd0, 5'd0};
        for (int p = 11; p < 15; p++)
            caps[p] = 5'($urandom_range(0, 31));
        per_phase = RAND_ITEMS / 15;
        for (int p = 0; p < 15; p++) begin
            set_capacity(caps[p]);
            no_idle = (p % 4 == 3);
            filling = 1'b1;
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 11) == 0)
                    filling = !filling;
                // now and then hold off until everything is back
                if ($urandom_range(0, 59) == 0)
                    drain();
                send_req(pick_cmd(filling), pick_data(), $urandom_range(0, 3) == 0,
                         pick_gap());
            end
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_capacity();
        test_single_entry();
        test_long_burst();
        test_random_traffic();

        drain();
        repeat (4) @(negedge i_clk);
        $display("sent %0d requests, checked %0d results, %0d capacity writes",
                 n_taken, n_checked, n_caps);
        $display("reads %0d, overwrite drops %0d, refusals %0d, full after %0d, errors %0d",
                 n_reads, n_drops, n_refused, n_full, n_err);
        if (n_err == 0 && due_rsp.size() == 0) begin
            $display("** ring_deque_with_overwrite: PASSED **");
        end else begin
            $display("** ring_deque_with_overwrite: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rdq_pkg.sv
rtl/core/rdq_ram.sv
rtl/core/rdq_ctrl.sv
rtl/core/ring_deque_with_overwrite.sv
sim/tb.sv
